FILE: rtl/edcd_pkg.sv
// ----------------------------------------------------------------------------
// edcd_pkg
// Shared types, constants and calendar helpers for the day count to date
// converter.
// ----------------------------------------------------------------------------
package edcd_pkg;

  localparam int unsigned DaysW   = 16;
  localparam int unsigned MinuteW = 11;
  localparam int unsigned TickW   = 12;
  localparam int unsigned YearW   = 8;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;

  localparam logic [MinuteW-1:0] MaxMinute = 11'd1439;
  localparam logic [TickW-1:0]   MaxTick   = 12'd2999;

  // floor(x / 60) and floor(x / 50) as multiply and shift, exact over the clamped range
  localparam int unsigned        RecipShift = 16;
  localparam logic [MinuteW-1:0] RecipMin   = 11'd1093;
  localparam logic [TickW-1:0]   RecipTick  = 12'd1311;
  localparam logic [TickW-1:0]   TicksPerSec = 12'd50;

  // year offsets from 1900
  localparam logic [YearW-1:0] EpochOff = 8'd78;
  localparam logic [YearW-1:0] LastOff  = 8'd255;
  localparam logic [YearW-1:0] Off2100  = 8'd200;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DayLast  = 5'd31;

  localparam logic [DaysW-1:0] DaysLeapYear = 16'd366;
  localparam logic [DaysW-1:0] DaysYear     = 16'd365;

  // one queued word from the front end
  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } q_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_YEAR,
    BK_MONTH,
    BK_DONE
  } bk_state_t;

  // Leap rule for 1900 + off, off in 0..255: 1900 and 2100 are century non-leap
  // years, 2000 is a leap year.
  function automatic logic leap_year(input logic [YearW-1:0] off);
    leap_year = (off[1:0] == 2'b00) && (off != Off2100) && (off != '0);
  endfunction

  function automatic logic [DaysW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DaysW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 16'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 16'd30;
      MonthFeb:                                   len = leap ? 16'd29 : 16'd28;
      default:                                    len = 16'd31;
    endcase
    month_len = len;
  endfunction

endpackage

FILE: rtl/epoch_days_to_calendar_date_top.sv
// ----------------------------------------------------------------------------
// epoch_days_to_calendar_date_top
// Day count since 1978-01-01 plus time of day in, Gregorian date and
// hour/minute/second out; dates past 2155-12-31 saturate and flag.
// ----------------------------------------------------------------------------
//  channel  | ports                                            | dir
//  ---------+--------------------------------------------------+-----
//  in       | in_valid, in_stall, days/minute/tick fields      | in
//  out      | out_valid, out_stall, date/time fields, range    | out
//
// The walker steps a word through the years past 1978 (up to 177) and then
// through the months (up to 11), one subtract a cycle.
// Words queue two deep in front of the walker; the output register lets the
// next word start while a result is stalled.
// Synchronous active-low reset empties the queue and drops out_valid.
module epoch_days_to_calendar_date_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [edcd_pkg::DaysW-1:0]   in_days_since_epoch,
  input  logic [edcd_pkg::MinuteW-1:0] in_minute_of_day,
  input  logic [edcd_pkg::TickW-1:0]   in_tick_in_minute,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [edcd_pkg::YearW-1:0]   out_year_offset,
  output logic [edcd_pkg::MonthW-1:0]  out_month_number,
  output logic [edcd_pkg::DayW-1:0]    out_day_of_month,
  output logic [edcd_pkg::HourW-1:0]   out_hour_of_day,
  output logic [edcd_pkg::MinW-1:0]    out_minute_of_hour,
  output logic [edcd_pkg::SecW-1:0]    out_second_of_minute,
  output logic                         out_out_of_range
);

  edcd_pkg::q_word_t front_word;
  edcd_pkg::q_word_t head_word;
  edcd_pkg::q_stat_t q_stat;
  logic              pop;

  edcd_front u_front (
    .days_since_epoch (in_days_since_epoch),
    .minute_of_day    (in_minute_of_day),
    .tick_in_minute   (in_tick_in_minute),
    .word             (front_word)
  );

  assign in_stall = q_stat.full;

  edcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_word (front_word),
    .pop       (pop),
    .head_word (head_word),
    .stat      (q_stat)
  );

  edcd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head_word            (head_word),
    .q_stat               (q_stat),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_year_offset      (out_year_offset),
    .out_month_number     (out_month_number),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .out_out_of_range     (out_out_of_range)
  );

endmodule

FILE: rtl/edcd_front.sv
// ----------------------------------------------------------------------------
// edcd_front
// Clamps the time of day and splits it into hour, minute and second, then
// hands the word to the queue together with the day count.
// ----------------------------------------------------------------------------
module edcd_front (
  input  logic [edcd_pkg::DaysW-1:0]   days_since_epoch,
  input  logic [edcd_pkg::MinuteW-1:0] minute_of_day,
  input  logic [edcd_pkg::TickW-1:0]   tick_in_minute,
  output edcd_pkg::q_word_t            word
);

  logic [edcd_pkg::MinuteW-1:0]   minute_c;
  logic [edcd_pkg::TickW-1:0]     tick_c;
  logic [2*edcd_pkg::MinuteW-1:0] min_prod;
  logic [2*edcd_pkg::TickW-1:0]   tick_prod;
  logic [edcd_pkg::HourW-1:0]     hour;
  logic [edcd_pkg::MinuteW-1:0]   hour_x60;
  logic [edcd_pkg::MinuteW-1:0]   min_rem;

  assign minute_c = (minute_of_day > edcd_pkg::MaxMinute) ? edcd_pkg::MaxMinute
                                                          : minute_of_day;
  assign tick_c   = (tick_in_minute > edcd_pkg::MaxTick) ? edcd_pkg::MaxTick
                                                         : tick_in_minute;

  assign min_prod  = {{edcd_pkg::MinuteW{1'b0}}, minute_c} *
                     {{edcd_pkg::MinuteW{1'b0}}, edcd_pkg::RecipMin};
  assign tick_prod = {{edcd_pkg::TickW{1'b0}}, tick_c} *
                     {{edcd_pkg::TickW{1'b0}}, edcd_pkg::RecipTick};

  assign hour = min_prod[edcd_pkg::RecipShift +: edcd_pkg::HourW];

  // hour * 60 = hour * 64 - hour * 4
  assign hour_x60 = ({{(edcd_pkg::MinuteW-edcd_pkg::HourW){1'b0}}, hour} << 6)
                  - ({{(edcd_pkg::MinuteW-edcd_pkg::HourW){1'b0}}, hour} << 2);
  assign min_rem  = minute_c - hour_x60;

  assign word.days   = days_since_epoch;
  assign word.hour   = hour;
  assign word.minute = min_rem[edcd_pkg::MinW-1:0];
  assign word.second = tick_prod[edcd_pkg::RecipShift +: edcd_pkg::SecW];

endmodule

FILE: rtl/edcd_queue.sv
// ----------------------------------------------------------------------------
// edcd_queue
// Two-word queue between the front end and the date walker.
// ----------------------------------------------------------------------------
module edcd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  edcd_pkg::q_word_t  push_word,
  input  logic               pop,
  output edcd_pkg::q_word_t  head_word,
  output edcd_pkg::q_stat_t  stat
);

  edcd_pkg::q_word_t q_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_word  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

FILE: rtl/edcd_back.sv
// ----------------------------------------------------------------------------
// edcd_back
// Walks years then months one step a cycle and fills the output register.
// ----------------------------------------------------------------------------
module edcd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  edcd_pkg::q_word_t           head_word,
  input  edcd_pkg::q_stat_t           q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [edcd_pkg::YearW-1:0]  out_year_offset,
  output logic [edcd_pkg::MonthW-1:0] out_month_number,
  output logic [edcd_pkg::DayW-1:0]   out_day_of_month,
  output logic [edcd_pkg::HourW-1:0]  out_hour_of_day,
  output logic [edcd_pkg::MinW-1:0]   out_minute_of_hour,
  output logic [edcd_pkg::SecW-1:0]   out_second_of_minute,
  output logic                        out_out_of_range
);

  edcd_pkg::bk_state_t st_r, st_nxt;

  logic [edcd_pkg::DaysW-1:0]  days_r, days_nxt;
  logic [edcd_pkg::YearW-1:0]  year_r, year_nxt;
  logic [edcd_pkg::MonthW-1:0] month_r, month_nxt;
  logic                        oor_r, oor_nxt;
  logic [edcd_pkg::HourW-1:0]  hour_r, hour_nxt;
  logic [edcd_pkg::MinW-1:0]   min_r, min_nxt;
  logic [edcd_pkg::SecW-1:0]   sec_r, sec_nxt;

  logic                        ov_r, ov_nxt;
  logic                        out_load;
  logic                        out_free;
  logic                        leap;
  logic [edcd_pkg::DaysW-1:0]  year_len;
  logic [edcd_pkg::DaysW-1:0]  mon_len;
  logic [edcd_pkg::DayW-1:0]   day_fin;

  assign leap     = edcd_pkg::leap_year(year_r);
  assign year_len = leap ? edcd_pkg::DaysLeapYear : edcd_pkg::DaysYear;
  assign mon_len  = edcd_pkg::month_len(month_r, leap);
  assign out_free = !ov_r || !out_stall;
  // days_r is below 31 once the month walk stops
  assign day_fin  = oor_r ? edcd_pkg::DayLast : (days_r[edcd_pkg::DayW-1:0] + 5'd1);

  always_comb begin
    st_nxt    = st_r;
    days_nxt  = days_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    oor_nxt   = oor_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    unique case (st_r)
      edcd_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          days_nxt  = head_word.days;
          hour_nxt  = head_word.hour;
          min_nxt   = head_word.minute;
          sec_nxt   = head_word.second;
          year_nxt  = edcd_pkg::EpochOff;
          month_nxt = edcd_pkg::MonthJan;
          oor_nxt   = 1'b0;
          st_nxt    = edcd_pkg::BK_YEAR;
        end
      end
      edcd_pkg::BK_YEAR: begin
        priority if (days_r < year_len) begin
          st_nxt = edcd_pkg::BK_MONTH;
        end else if (year_r == edcd_pkg::LastOff) begin
          oor_nxt = 1'b1;
          st_nxt  = edcd_pkg::BK_DONE;
        end else begin
          days_nxt = days_r - year_len;
          year_nxt = year_r + 8'd1;
        end
      end
      edcd_pkg::BK_MONTH: begin
        priority if (month_r == edcd_pkg::MonthDec || days_r < mon_len) begin
          st_nxt = edcd_pkg::BK_DONE;
        end else begin
          days_nxt  = days_r - mon_len;
          month_nxt = month_r + 4'd1;
        end
      end
      edcd_pkg::BK_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          st_nxt   = edcd_pkg::BK_IDLE;
        end
      end
      default: st_nxt = edcd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_load) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= edcd_pkg::BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    days_r  <= days_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    oor_r   <= oor_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
    if (out_load) begin
      out_year_offset      <= year_r;
      out_month_number     <= oor_r ? edcd_pkg::MonthDec : month_r;
      out_day_of_month     <= day_fin;
      out_hour_of_day      <= hour_r;
      out_minute_of_hour   <= min_r;
      out_second_of_minute <= sec_r;
      out_out_of_range     <= oor_r;
    end
  end

  assign out_valid = ov_r;

endmodule

FILE: rtl/edcd_checker.sv
// ----------------------------------------------------------------------------
// edcd_checker
// Port-level checks on the converter's result channel.
// ----------------------------------------------------------------------------
module edcd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [edcd_pkg::YearW-1:0]   out_year_offset,
  input logic [edcd_pkg::MonthW-1:0]  out_month_number,
  input logic [edcd_pkg::DayW-1:0]    out_day_of_month,
  input logic [edcd_pkg::HourW-1:0]   out_hour_of_day,
  input logic [edcd_pkg::MinW-1:0]    out_minute_of_hour,
  input logic [edcd_pkg::SecW-1:0]    out_second_of_minute,
  input logic                         out_out_of_range
);

  // a stalled word keeps its date fields and range flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year_offset)
      && $stable(out_month_number) && $stable(out_day_of_month)
      && $stable(out_out_of_range))
    else $error("result word changed while stalled");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_number >= edcd_pkg::MonthJan
      && out_month_number <= edcd_pkg::MonthDec
      && out_day_of_month != '0 && out_year_offset >= edcd_pkg::EpochOff)
    else $error("date field out of range");

  // saturated date on overflow
  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_year_offset == edcd_pkg::LastOff
      && out_month_number == edcd_pkg::MonthDec
      && out_day_of_month == edcd_pkg::DayLast)
    else $error("out of range date not saturated");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour_of_day <= 5'd23 && out_minute_of_hour <= 6'd59
      && out_second_of_minute <= 6'd59)
    else $error("time field out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind epoch_days_to_calendar_date_top edcd_checker u_edcd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_year_offset      (out_year_offset),
  .out_month_number     (out_month_number),
  .out_day_of_month     (out_day_of_month),
  .out_hour_of_day      (out_hour_of_day),
  .out_minute_of_hour   (out_minute_of_hour),
  .out_second_of_minute (out_second_of_minute),
  .out_out_of_range     (out_out_of_range)
);

FILE: test/epoch_days_to_calendar_date_top_test.sv
// ----------------------------------------------------------------------------
// epoch_days_to_calendar_date_top_test
// Self-checking bench for the day count to calendar date converter. Directed
// calendar corners first, then bursts of random timestamps with random gaps
// and output stalls, each result checked field by field against a predicted
// date kept in a scoreboard.
// ----------------------------------------------------------------------------
module epoch_days_to_calendar_date_top_test;
  import edcd_pkg::*;

  typedef struct {
    logic [YearW-1:0]  year_off;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic              oor;
  } date_word_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  localparam int unsigned FirstYear   = 1978;
  localparam int unsigned FinalYear   = 2155;
  localparam int unsigned BaseYear    = 1900;
  localparam int unsigned RandomWords = 630;
  localparam int unsigned TailCycles  = 250;

  class calendar_checker;
    date_word_t  pending_dates[$];
    int unsigned errors;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned saturated;
    int unsigned clamped;

    function new();
      errors    = 0;
      words_in  = 0;
      words_out = 0;
      saturated = 0;
      clamped   = 0;
    endfunction

    static function bit is_leap(int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    static function int unsigned month_length(int unsigned mo, int unsigned yr);
      case (mo)
        4, 6, 9, 11: return 30;
        MonthFeb:    return is_leap(yr) ? 29 : 28;
        default:     return 31;
      endcase
    endfunction

    function date_word_t civil_date_of(logic [DaysW-1:0] days,
                                       logic [MinuteW-1:0] mins,
                                       logic [TickW-1:0] ticks);
      date_word_t  w;
      int unsigned left;
      int unsigned yr;
      int unsigned mo;
      int unsigned ylen;
      int unsigned mlen;
      int unsigned min_c;
      int unsigned tick_c;
      bit          sat;
      left = 32'(days);
      yr   = FirstYear;
      mo   = 1;
      sat  = 1'b0;
      while (1'b1) begin
        ylen = is_leap(yr) ? 366 : 365;
        if (left < ylen) break;
        if (yr == FinalYear) begin
          sat = 1'b1;
          break;
        end
        left -= ylen;
        yr++;
      end
      if (sat) begin
        // pinned to the last representable day
        mo   = 32'(MonthDec);
        left = 32'(DayLast) - 1;
      end else begin
        while (mo < 12) begin
          mlen = month_length(mo, yr);
          if (left < mlen) break;
          left -= mlen;
          mo++;
        end
      end
      min_c  = 32'((mins > MaxMinute) ? MaxMinute : mins);
      tick_c = 32'((ticks > MaxTick) ? MaxTick : ticks);
      w.year_off = YearW'(yr - BaseYear);
      w.month    = MonthW'(mo);
      w.day      = DayW'(left + 1);
      w.hour     = HourW'(min_c / 60);
      w.minute   = MinW'(min_c % 60);
      w.second   = SecW'(tick_c / 32'(TicksPerSec));
      w.oor      = sat;
      return w;
    endfunction

    function void note_timestamp(logic [DaysW-1:0] days, logic [MinuteW-1:0] mins,
                                 logic [TickW-1:0] ticks);
      pending_dates.push_back(civil_date_of(days, mins, ticks));
      words_in++;
      if (mins > MaxMinute || ticks > MaxTick) clamped++;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_date(date_word_t got);
      date_word_t want;
      if (pending_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %0d-%0d-%0d", $time,
                 got.year_off, got.month, got.day);
        return;
      end
      want = pending_dates.pop_front();
      words_out++;
      if (got.oor === 1'b1) saturated++;
      check_field("year_offset", 16'(want.year_off), 16'(got.year_off));
      check_field("month_number", 16'(want.month), 16'(got.month));
      check_field("day_of_month", 16'(want.day), 16'(got.day));
      check_field("hour_of_day", 16'(want.hour), 16'(got.hour));
      check_field("minute_of_hour", 16'(want.minute), 16'(got.minute));
      check_field("second_of_minute", 16'(want.second), 16'(got.second));
      check_field("out_of_range", 16'(want.oor), 16'(got.oor));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [DaysW-1:0]   in_days_since_epoch;
  logic [MinuteW-1:0] in_minute_of_day;
  logic [TickW-1:0]   in_tick_in_minute;
  logic               out_valid;
  logic               out_stall;
  logic [YearW-1:0]   out_year_offset;
  logic [MonthW-1:0]  out_month_number;
  logic [DayW-1:0]    out_day_of_month;
  logic [HourW-1:0]   out_hour_of_day;
  logic [MinW-1:0]    out_minute_of_hour;
  logic [SecW-1:0]    out_second_of_minute;
  logic               out_out_of_range;

  calendar_checker calendar;

  epoch_days_to_calendar_date_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_days_since_epoch  (in_days_since_epoch),
    .in_minute_of_day     (in_minute_of_day),
    .in_tick_in_minute    (in_tick_in_minute),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_year_offset      (out_year_offset),
    .out_month_number     (out_month_number),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .out_out_of_range     (out_out_of_range)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // day count of 1 January of the given year
  function automatic int unsigned year_start(int unsigned yr);
    int unsigned total;
    total = 0;
    for (int unsigned y = FirstYear; y < yr; y++)
      total += calendar_checker::is_leap(y) ? 366 : 365;
    return total;
  endfunction

  function automatic logic [DaysW-1:0] pick_days();
    int          offsets[13] = '{-1, 0, 1, 28, 30, 31, 58, 59, 60, 333, 334, 364, 365};
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 99);
    if (sel < 55) return DaysW'($urandom_range(0, 65535));
    if (sel < 65) return DaysW'($urandom_range(0, 800));
    if (sel < 75) return DaysW'($urandom_range(64900, 65535));
    // land on or next to a year or month boundary
    v = int'(year_start($urandom_range(FirstYear, FinalYear + 1)))
      + offsets[$urandom_range(0, 12)];
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DaysW'(v);
  endfunction

  function automatic logic [MinuteW-1:0] pick_minute();
    if ($urandom_range(0, 99) < 85) return MinuteW'($urandom_range(0, 1439));
    return MinuteW'($urandom_range(1440, 2047));
  endfunction

  function automatic logic [TickW-1:0] pick_tick();
    if ($urandom_range(0, 99) < 85) return TickW'($urandom_range(0, 2999));
    return TickW'($urandom_range(3000, 4095));
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_word(input logic [DaysW-1:0] days, input logic [MinuteW-1:0] mins,
                           input logic [TickW-1:0] ticks);
    bit taken;
    in_valid            <= 1'b1;
    in_days_since_epoch <= days;
    in_minute_of_day    <= mins;
    in_tick_in_minute   <= ticks;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    calendar.note_timestamp(days, mins, ticks);
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_days_since_epoch <= '0;
    in_minute_of_day    <= '0;
    in_tick_in_minute   <= '0;
    calendar = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(16'd0, 11'd0, 12'd0);
    send_word(16'd364, 11'd1439, 12'd2999);
    send_word(16'd365, 11'd60, 12'd50);
    send_word(DaysW'(year_start(1980) + 59), 11'd720, 12'd49);
    send_word(DaysW'(year_start(1980) + 60), 11'd1440, 12'd3000);
    send_word(DaysW'(year_start(1980) + 365), 11'd2047, 12'd4095);
    send_word(DaysW'(year_start(1981) - 1), 11'd1023, 12'd2048);
    send_word(DaysW'(year_start(2000) + 59), 11'd59, 12'd2950);
    send_word(DaysW'(year_start(2000) + 365), 11'd61, 12'd2999);
    send_word(DaysW'(year_start(2100) + 58), 11'd1380, 12'd1);
    send_word(DaysW'(year_start(2100) + 59), 11'd1024, 12'd3001);
    send_word(DaysW'(year_start(2155)), 11'd1, 12'd100);
    send_word(DaysW'(year_start(FinalYear + 1) - 1), 11'd1439, 12'd2999);
    send_word(DaysW'(year_start(FinalYear + 1)), 11'd0, 12'd0);
    send_word(16'h8000, 11'd1500, 12'd4000);
    send_word(16'hFFFF, 11'd2047, 12'd4095);
    idle_for(20);

    sent = 0;
    while (sent < RandomWords) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_word(pick_days(), pick_minute(), pick_tick());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 250));
    end
    idle_for(1);

    while (calendar.pending_dates.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("checked %0d of %0d timestamps: %0d saturated past the last year, %0d with",
             calendar.words_out, calendar.words_in, calendar.saturated, calendar.clamped);
    $display("clamped time fields, under random input gaps and output stalls");
    if (calendar.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // receiver back-pressure, switching between a few stall patterns
  initial begin
    stall_mode_t mode;
    int unsigned left_cycles;
    int unsigned phase;
    out_stall <= 1'b0;
    mode        = STALL_NONE;
    left_cycles = 0;
    phase       = 0;
    forever begin
      @(posedge clk);
      if (left_cycles == 0) begin
        mode        = stall_mode_t'($urandom_range(0, 3));
        left_cycles = $urandom_range(50, 400);
      end
      left_cycles--;
      phase++;
      case (mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= ((phase % 11) < 4);
        default:        out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // outputs are stable at the falling edge; a word seen here is taken next edge
  always @(negedge clk) begin : sample_result
    date_word_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.year_off = out_year_offset;
      got.month    = out_month_number;
      got.day      = out_day_of_month;
      got.hour     = out_hour_of_day;
      got.minute   = out_minute_of_hour;
      got.second   = out_second_of_minute;
      got.oor      = out_out_of_range;
      calendar.check_date(got);
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
